// File: rtl/core/dndl_pkg.sv
package dndl_pkg;

    localparam int LABEL_MAX_DEF = 62;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef struct packed {
        logic [7:0] name_char;
        logic       end_of_name;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       name_done;
        logic       label_too_long;
    } out_item_t;

    typedef enum logic {
        CMD_BUF,
        CMD_FLUSH
    } cmd_op_t;

    // One queued job for the back end: store a character, or flush the label
    // (data then holds the label length).
    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
        logic       tl;
        logic       term;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_CHAR,
        ST_TERM
    } back_state_t;

endpackage

// File: rtl/core/dndl_front.sv
module dndl_front
    import dndl_pkg::*;
#(
    parameter int LABEL_MAX = LABEL_MAX_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     q_full,
    output logic     q_push,
    output cmd_t     q_cmd
);

    localparam int CNT_W = $clog2(LABEL_MAX + 1);

    logic [CNT_W-1:0] label_count_reg, label_count_next;
    logic             no_split_reg, no_split_next;
    logic             overflowed_reg, overflowed_next;
    logic             accept;
    logic             is_dot;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign is_dot  = (s_data.name_char == DOT_CHAR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            label_count_reg <= '0;
            no_split_reg    <= 1'b0;
            overflowed_reg  <= 1'b0;
        end else begin
            label_count_reg <= label_count_next;
            no_split_reg    <= no_split_next;
            overflowed_reg  <= overflowed_next;
        end
    end

    always_comb begin
        label_count_next = label_count_reg;
        no_split_next    = no_split_reg;
        overflowed_next  = overflowed_reg;
        q_push           = 1'b0;
        q_cmd.op         = CMD_BUF;
        q_cmd.data       = s_data.name_char;
        q_cmd.tl         = overflowed_reg;
        q_cmd.term       = 1'b0;
        if (accept) begin
            if (s_data.end_of_name) begin
                q_push           = 1'b1;
                q_cmd.op         = CMD_FLUSH;
                q_cmd.data       = 8'(label_count_reg);
                q_cmd.term       = 1'b1;
                label_count_next = '0;
                overflowed_next  = 1'b0;
                no_split_next    = 1'b0;
            end else if (is_dot && !no_split_reg && label_count_reg != '0) begin
                q_push           = 1'b1;
                q_cmd.op         = CMD_FLUSH;
                q_cmd.data       = 8'(label_count_reg);
                label_count_next = '0;
                overflowed_next  = 1'b0;
            end else begin
                // a dot on an empty label stops splitting and is kept as a character
                if (is_dot && !no_split_reg) begin
                    no_split_next = 1'b1;
                end
                if (label_count_reg < CNT_W'(LABEL_MAX)) begin
                    q_push           = 1'b1;
                    label_count_next = label_count_reg + CNT_W'(1);
                end else begin
                    overflowed_next = 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/core/dndl_queue.sv
module dndl_queue
    import dndl_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_cmd
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    cmd_t             entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   fill_reg, fill_next;
    logic             do_push, do_pop;

    assign full    = (fill_reg == (PTR_W + 1)'(DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_cmd   = entries[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + (PTR_W + 1)'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/dndl_back.sv
module dndl_back
    import dndl_pkg::*;
#(
    parameter int LABEL_MAX = LABEL_MAX_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int CNT_W  = $clog2(LABEL_MAX + 1);
    localparam int ADDR_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

    logic [7:0]        mem [LABEL_MAX];
    logic [7:0]        rd_data_reg;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr;

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic              tl_reg, tl_next;
    logic              term_reg, term_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;
    logic              out_free;
    logic              load;
    logic [CNT_W-1:0]  idx_inc;

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign idx_inc  = idx_reg + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wr_ptr_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wr_ptr_reg  <= wr_ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        len_reg    <= len_next;
        tl_reg     <= tl_next;
        term_reg   <= term_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= q_cmd.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        state_next  = state_reg;
        wr_ptr_next = wr_ptr_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        tl_next     = tl_reg;
        term_next   = term_reg;
        m_data_next = m_data_reg;
        load        = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        q_pop       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_cmd.op == CMD_BUF) begin
                        wr_en       = 1'b1;
                        wr_ptr_next = wr_ptr_reg + ADDR_W'(1);
                    end else begin
                        len_next    = q_cmd.data[CNT_W-1:0];
                        tl_next     = q_cmd.tl;
                        term_next   = q_cmd.term;
                        idx_next    = '0;
                        wr_ptr_next = '0;
                        state_next  = ST_LEN;
                    end
                end
            end
            ST_LEN: begin
                if (out_free) begin
                    load                       = 1'b1;
                    m_data_next.out_byte       = 8'(len_reg);
                    m_data_next.run_last       = (len_reg == '0) && !term_reg;
                    m_data_next.name_done      = 1'b0;
                    m_data_next.label_too_long = tl_reg;
                    idx_next                   = '0;
                    if (len_reg != '0) begin
                        // prefetch the first character
                        rd_en      = 1'b1;
                        state_next = ST_CHAR;
                    end else begin
                        state_next = term_reg ? ST_TERM : ST_IDLE;
                    end
                end
            end
            ST_CHAR: begin
                if (out_free) begin
                    load                       = 1'b1;
                    m_data_next.out_byte       = rd_data_reg;
                    m_data_next.run_last       = (idx_inc == len_reg) && !term_reg;
                    m_data_next.name_done      = 1'b0;
                    m_data_next.label_too_long = tl_reg;
                    if (idx_inc == len_reg) begin
                        state_next = term_reg ? ST_TERM : ST_IDLE;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc[ADDR_W-1:0];
                        idx_next = idx_inc;
                    end
                end
            end
            ST_TERM: begin
                if (out_free) begin
                    load                       = 1'b1;
                    m_data_next.out_byte       = 8'd0;
                    m_data_next.run_last       = 1'b1;
                    m_data_next.name_done      = 1'b1;
                    m_data_next.label_too_long = 1'b0;
                    state_next                 = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = load ? 1'b1 : (m_valid_reg && !m_ready);
    end

endmodule

// File: rtl/core/dotted_name_to_dns_labels_core.sv
// Dotted domain name to DNS wire-format labels.
// Input channel (s_valid/s_ready/s_data): one character of the name per word,
// or an end-of-name word. Output channel (m_valid/m_ready/m_data): wire bytes,
// each label as a length byte and its characters, then a zero terminator.
// run_last marks the final byte caused by one input word.
// Plain characters are taken one per cycle unless the job queue is full; they
// pass a two-entry job queue into the back end, which writes them to the label
// memory. A dot or end-of-name word that flushes a label passes the job queue
// and the back end's ST_LEN state before its first byte reaches the m_*
// register; the flush then streams one byte per cycle while m_ready is high:
// the length byte, the label's characters and, at end of name, the terminator.
// While a flush streams, the front keeps taking words until the job queue is
// full, then holds s_ready low.
// When m_ready is low the output register holds its word and the flush pauses.
// Reset (aresetn low, synchronous) empties the queue, drops any result in
// flight and clears the label count and the split state; the label memory is
// not cleared.
module dotted_name_to_dns_labels_core
    import dndl_pkg::*;
#(
    parameter int LABEL_MAX = LABEL_MAX_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic q_full, q_push, q_pop, q_valid;
    cmd_t push_cmd, head_cmd;

    dndl_front #(
        .LABEL_MAX(LABEL_MAX)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    dndl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd)
    );

    dndl_back #(
        .LABEL_MAX(LABEL_MAX)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: rtl/core/dndl_checker.sv
module dndl_checker
    import dndl_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // terminator is a zero byte that ends its run and carries no error flag
    a_term_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.name_done |->
            m_data.run_last && (m_data.out_byte == 8'd0) && !m_data.label_too_long)
        else $error("malformed terminator");

    // reset drops any word in flight
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind dotted_name_to_dns_labels_core dndl_checker u_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
